FILE: hdl/cns_pkg.sv
// Shared types and constants for the column negative sort core.
package cns_pkg;

    localparam int SIZE_W = 4;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    // Write data source for the matrix store
    localparam logic WR_SRC_IN  = 1'b0;
    localparam logic WR_SRC_CUR = 1'b1;

    typedef struct packed {
        logic we;        // write the store at the write address
        logic wr_src;    // WR_SRC_IN or WR_SRC_CUR
        logic rd;        // read the store at the read address
        logic cur_load;  // take read data into the held element
        logic out_en;    // the read of this cycle yields a result
        logic out_last;  // it is the final one of the matrix
    } t_dp_cmd;

    typedef struct packed {
        logic swap;      // both negative and held element is larger
    } t_dp_sts;

endpackage

FILE: hdl/column_negative_sort_core.sv
// Column negative sort core: top level joining sequencer and datapath.
//
// Elements of an n by n matrix (n from the size register, 1..MAX_SIZE) are
// taken one per cycle on start while busy is low, in row-major order. After
// the last element busy rises; each column's negative values are then put in
// ascending order in the rows that held negatives, by a compare-exchange scan
// through the single-port-write, registered-read store; each compare first
// reads the scanned element, and each row reads, loads and writes back the
// held element. The matrix then leaves in row-major order, one element per
// cycle, each shown for one cycle with o_result_valid and the final one with
// o_result_last. The receiver cannot stall: it must take every result in the
// cycle it shows. Size writes are taken while busy is low and start is not
// raised; they discard a partly loaded matrix.
module column_negative_sort_core
    import cns_pkg::*;
#(
    parameter int MAX_SIZE   = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [DATA_WIDTH-1:0] i_element_value,
    output logic [DATA_WIDTH-1:0] o_result_value,
    output logic                  o_result_last,
    output logic                  o_result_valid,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [SIZE_W-1:0]     i_cfg_data
);

    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_SIZE + 1);
    localparam int TW    = 2 * CW;

    t_dp_cmd       cmd;
    t_dp_sts       sts;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;

    // an offered element goes before a size write
    assign o_cfg_ready = !busy && !start;

    cns_ctrl #(
        .MAX_SIZE (MAX_SIZE),
        .AW       (AW),
        .CW       (CW),
        .TW       (TW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_size (i_cfg_data),
        .i_sts      (sts),
        .o_busy     (busy),
        .o_cmd      (cmd),
        .o_waddr    (waddr),
        .o_raddr    (raddr)
    );

    cns_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .DEPTH      (DEPTH),
        .AW         (AW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_waddr        (waddr),
        .i_raddr        (raddr),
        .i_wdata_in     (i_element_value),
        .o_sts          (sts),
        .o_result_value (o_result_value),
        .o_result_valid (o_result_valid),
        .o_result_last  (o_result_last)
    );

endmodule

FILE: hdl/cns_datapath.sv
// Matrix store, held element, compare-exchange and result register.
module cns_datapath
    import cns_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int DEPTH      = 64,
    parameter int AW         = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [AW-1:0]         i_waddr,
    input  logic [AW-1:0]         i_raddr,
    input  logic [DATA_WIDTH-1:0] i_wdata_in,
    output t_dp_sts               o_sts,
    output logic [DATA_WIDTH-1:0] o_result_value,
    output logic                  o_result_valid,
    output logic                  o_result_last
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [DATA_WIDTH-1:0] r_cur;
    logic                  r_out_vld;
    logic                  r_out_last;
    logic                  swap;
    logic [DATA_WIDTH-1:0] mem_wdata;

    // Both negative: signed order equals the ordering key
    assign swap = r_cur[DATA_WIDTH-1] && r_rdata[DATA_WIDTH-1]
                  && ($signed(r_cur) > $signed(r_rdata));

    assign mem_wdata = (i_cmd.wr_src == WR_SRC_CUR) ? r_cur : i_wdata_in;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_waddr] <= mem_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cur_load) begin
            r_cur <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            r_out_vld  <= i_cmd.out_en;
            r_out_last <= i_cmd.out_en && i_cmd.out_last;
        end
    end

    assign o_sts.swap     = swap;
    assign o_result_value = r_rdata;
    assign o_result_valid = r_out_vld;
    assign o_result_last  = r_out_last;

endmodule

FILE: hdl/cns_ctrl.sv
// Sequencer: load, per-column exchange sort of negatives, and readout.
module cns_ctrl
    import cns_pkg::*;
#(
    parameter int MAX_SIZE = 8,
    parameter int AW       = 6,
    parameter int CW       = 4,
    parameter int TW       = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_size,
    input  t_dp_sts           i_sts,
    output logic              o_busy,
    output t_dp_cmd           o_cmd,
    output logic [AW-1:0]     o_waddr,
    output logic [AW-1:0]     o_raddr
);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_RDA  = 3'd1;
    localparam logic [2:0] S_LDA  = 3'd2;
    localparam logic [2:0] S_RDB  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_WRA  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [SIZE_W-1:0] r_size,  n_size;
    logic [TW-1:0]     r_load,  n_load;
    logic [TW-1:0]     r_k,     n_k;
    logic [CW-1:0]     r_row,   n_row;
    logic [CW-1:0]     r_scan,  n_scan;
    logic [CW-1:0]     r_col,   n_col;

    logic [CW-1:0]     size_n;
    logic [TW-1:0]     total;
    logic [TW-1:0]     addr_a;
    logic [TW-1:0]     addr_b;
    logic              load_done;

    // Size zero counts as one, anything above the maximum as the maximum
    always_comb begin
        priority if (r_size == '0) begin
            size_n = CW'(1);
        end else if (r_size > SIZE_W'(MAX_SIZE)) begin
            size_n = CW'(MAX_SIZE);
        end else begin
            size_n = CW'(r_size);
        end
    end

    assign total     = TW'(size_n) * TW'(size_n);
    assign addr_a    = TW'(r_row) * TW'(size_n) + TW'(r_col);
    assign addr_b    = TW'(r_scan) * TW'(size_n) + TW'(r_col);
    assign load_done = (r_load + TW'(1)) == total;

    always_comb begin
        n_state = r_state;
        n_size  = r_size;
        n_load  = r_load;
        n_k     = r_k;
        n_row   = r_row;
        n_scan  = r_scan;
        n_col   = r_col;
        o_cmd   = '0;
        o_waddr = '0;
        o_raddr = '0;
        unique case (r_state)
            S_LOAD: begin
                o_waddr = r_load[AW-1:0];
                if (i_cfg_we) begin
                    n_size = i_cfg_size;
                    n_load = '0;
                end else if (i_start) begin
                    o_cmd.we     = 1'b1;
                    o_cmd.wr_src = WR_SRC_IN;
                    if (load_done) begin
                        n_load = '0;
                        n_row  = '0;
                        n_col  = '0;
                        n_k    = '0;
                        n_state = (size_n == CW'(1)) ? S_OUT : S_RDA;
                    end else begin
                        n_load = r_load + TW'(1);
                    end
                end
            end
            S_RDA: begin
                o_raddr  = addr_a[AW-1:0];
                o_cmd.rd = 1'b1;
                n_state  = S_LDA;
            end
            S_LDA: begin
                o_cmd.cur_load = 1'b1;
                n_scan  = r_row + CW'(1);
                n_state = S_RDB;
            end
            S_RDB: begin
                o_raddr  = addr_b[AW-1:0];
                o_cmd.rd = 1'b1;
                n_state  = S_CMP;
            end
            S_CMP: begin
                // swap writes the held element to row scan and keeps the smaller one
                o_cmd.we       = i_sts.swap;
                o_cmd.cur_load = i_sts.swap;
                o_cmd.wr_src   = WR_SRC_CUR;
                o_waddr        = addr_b[AW-1:0];
                n_scan         = r_scan + CW'(1);
                n_state        = ((r_scan + CW'(1)) == size_n) ? S_WRA : S_RDB;
            end
            S_WRA: begin
                o_cmd.we     = 1'b1;
                o_cmd.wr_src = WR_SRC_CUR;
                o_waddr      = addr_a[AW-1:0];
                if ((r_row + CW'(2)) == size_n) begin
                    n_row = '0;
                    n_col = r_col + CW'(1);
                    n_state = ((r_col + CW'(1)) == size_n) ? S_OUT : S_RDA;
                end else begin
                    n_row   = r_row + CW'(1);
                    n_state = S_RDA;
                end
            end
            S_OUT: begin
                o_raddr        = r_k[AW-1:0];
                o_cmd.rd       = 1'b1;
                o_cmd.out_en   = 1'b1;
                o_cmd.out_last = (r_k + TW'(1)) == total;
                n_k            = r_k + TW'(1);
                if ((r_k + TW'(1)) == total) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_busy = (r_state != S_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_size  <= SIZE_RESET;
            r_load  <= '0;
            r_k     <= '0;
            r_row   <= '0;
            r_scan  <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
            r_load  <= n_load;
            r_k     <= n_k;
            r_row   <= n_row;
            r_scan  <= n_scan;
            r_col   <= n_col;
        end
    end

endmodule

FILE: hdl/cns_checker.sv
// Port-level checks on the column negative sort core, bound to the top level.
module cns_checker
    import cns_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_result_valid,
    input logic o_result_last
);

    // results only follow a busy cycle
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result shown without preceding busy cycle");

    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_last |-> o_result_valid)
        else $error("last marker without result strobe");

    // busy drops exactly when the final element goes out
    a_busy_fall_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> (o_result_valid && o_result_last))
        else $error("busy fell without final element");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result_last) |=> !o_result_valid)
        else $error("result strobe right after final element");

endmodule

bind column_negative_sort_core cns_checker u_cns_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result_last  (o_result_last)
);
